// ----- hdl/cpt_pkg.sv -----
// Shared constants, types and rounding helper for the curve point pivot transform.
// Used by cpt_rot_angle, cpt_cordic and curve_point_pivot_transform; no dependencies.
package cpt_pkg;

   // Fixed-point layout.
   localparam int EXTRA_BITS       = 8;
   localparam int SCALE_FRAC       = 12;
   localparam int TRIG_FRAC        = 20;
   localparam int CORDIC_DROP      = 10;
   localparam int ELL_SHIFT        = 12;
   localparam int PAR_SHIFT_BASE   = 16;

   // Rotation angle conversion: round(a * 2^32 / 23040) = a * Q + floor((a * R + 22) / 45).
   localparam int unsigned DEG64_PER_TURN = 23040;
   localparam int unsigned ROT_Q_INT      = 186413;
   localparam int unsigned ROT_Q_REM      = 23;
   localparam int unsigned ROT_Q_BIAS     = 22;
   localparam int unsigned RECIP45        = 1491309;
   localparam int          RECIP45_SH     = 26;

   // Datapath widths.
   localparam int TRIG_W = 22;
   localparam int CORD_W = 33;
   localparam int P_W    = 40;
   localparam int D_W    = 41;
   localparam int SP_W   = 58;
   localparam int X_W    = 46;
   localparam int RP_W   = 68;
   localparam int RS_W   = 69;
   localparam int R_W    = 49;
   localparam int T_W    = 51;
   localparam int RND_W  = 72;

   localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 33'sd652032874;

   // Arctangent of 2^-i in units of 2^-32 turn.
   localparam int ATAN_N = 24;
   localparam logic [31:0] ATAN_TURN32 [ATAN_N] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
      32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
   };

   typedef enum logic [2:0] {
      REG_PIVOT_X    = 3'd0,
      REG_PIVOT_Y    = 3'd1,
      REG_SCALE_H    = 3'd2,
      REG_SCALE_V    = 3'd3,
      REG_ROTATION   = 3'd4,
      REG_SHIFT_X    = 3'd5,
      REG_SHIFT_Y    = 3'd6
   } reg_index_type;

   typedef enum logic {
      CMD_ELLIPSE  = 1'b0,
      CMD_PARABOLA = 1'b1
   } command_type;

   // Arithmetic right shift with rounding half away from zero (sh >= 1).
   function automatic logic signed [RND_W-1:0] rnd_shift(input logic signed [RND_W-1:0] v,
                                                         input int unsigned sh);
      logic signed [RND_W-1:0] half;
      logic signed [RND_W-1:0] sum;
      half = '0;
      half[sh-1] = 1'b1;
      sum = v + half;
      if (v[RND_W-1]) begin
         sum = sum - 72'sd1;
      end
      return sum >>> sh;
   endfunction

endpackage

// ----- hdl/cpt_rot_angle.sv -----
// Four-stage conversion of the rotation register (1/64 degree) to a 2^-32 turn angle.
// Depends on cpt_pkg.
module cpt_rot_angle
   import cpt_pkg::*;
(
   input  logic        clock,
   input  logic        en,
   input  logic [14:0] angle_deg64,
   output logic [31:0] rot_turn
);

   logic [14:0] a_mod_in, a_mod_ff;
   logic [31:0] p1_in, p1_ff;
   logic [19:0] r_in, r_ff;
   logic [31:0] p1b_ff;
   logic [40:0] prod_in;
   logic [14:0] lo_in, lo_ff;
   logic [31:0] rot_in, rot_ff;

   // Wrap modulo a full turn, split into integer quotient part and remainder part,
   // divide the remainder part by 45 through a reciprocal multiply, then sum.
   always_comb begin
      a_mod_in = (angle_deg64 >= 15'(DEG64_PER_TURN)) ?
                 angle_deg64 - 15'(DEG64_PER_TURN) : angle_deg64;
      p1_in    = 32'(a_mod_ff) * 32'(ROT_Q_INT);
      r_in     = 20'(a_mod_ff) * 20'(ROT_Q_REM) + 20'(ROT_Q_BIAS);
      prod_in  = 41'(r_ff) * 41'(RECIP45);
      lo_in    = 15'(prod_in >> RECIP45_SH);
      rot_in   = p1b_ff + 32'(lo_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_mod_ff <= a_mod_in;
         p1_ff    <= p1_in;
         r_ff     <= r_in;
         p1b_ff   <= p1_ff;
         lo_ff    <= lo_in;
         rot_ff   <= rot_in;
      end
   end

   assign rot_turn = rot_ff;

endmodule

// ----- hdl/cpt_cordic.sv -----
// Pipelined CORDIC giving cosine and sine in Q20 from a 2^-32 turn angle.
// The pipeline is STAGES + 2 register ranks; depends on cpt_pkg.
module cpt_cordic
   import cpt_pkg::*;
#(
   parameter int STAGES = 16
)
(
   input  logic                     clock,
   input  logic                     en,
   input  logic [31:0]              angle,
   output logic signed [TRIG_W-1:0] cos_q20,
   output logic signed [TRIG_W-1:0] sin_q20
);

   logic signed [CORD_W-1:0] x_in [STAGES+1];
   logic signed [CORD_W-1:0] y_in [STAGES+1];
   logic signed [CORD_W-1:0] z_in [STAGES+1];
   logic                     n_in [STAGES+1];
   logic signed [CORD_W-1:0] x_ff [STAGES+1];
   logic signed [CORD_W-1:0] y_ff [STAGES+1];
   logic signed [CORD_W-1:0] z_ff [STAGES+1];
   logic                     n_ff [STAGES+1];
   logic signed [CORD_W-1:0] z_raw;
   logic signed [CORD_W-1:0] atan_s;
   logic signed [TRIG_W-1:0] cx, sy;
   logic signed [TRIG_W-1:0] cos_in, sin_in, cos_ff, sin_ff;

   always_comb begin
      // Fold the angle by a half turn into the converging range.
      z_raw = CORD_W'($signed(angle));
      x_in[0] = CORDIC_GAIN;
      y_in[0] = '0;
      n_in[0] = 1'b0;
      z_in[0] = z_raw;
      if (z_raw > 33'sh040000000) begin
         z_in[0] = z_raw - 33'sh080000000;
         n_in[0] = 1'b1;
      end else if (z_raw < -33'sh040000000) begin
         z_in[0] = z_raw + 33'sh080000000;
         n_in[0] = 1'b1;
      end

      // One micro-rotation per stage.
      for (int j = 1; j <= STAGES; j++) begin
         atan_s = $signed({1'b0, ATAN_TURN32[j-1]});
         n_in[j] = n_ff[j-1];
         if (!z_ff[j-1][CORD_W-1]) begin
            x_in[j] = x_ff[j-1] - (y_ff[j-1] >>> (j-1));
            y_in[j] = y_ff[j-1] + (x_ff[j-1] >>> (j-1));
            z_in[j] = z_ff[j-1] - atan_s;
         end else begin
            x_in[j] = x_ff[j-1] + (y_ff[j-1] >>> (j-1));
            y_in[j] = y_ff[j-1] - (x_ff[j-1] >>> (j-1));
            z_in[j] = z_ff[j-1] + atan_s;
         end
      end

      // Drop to Q20 and undo the fold.
      cx = TRIG_W'(rnd_shift(RND_W'(x_ff[STAGES]), CORDIC_DROP));
      sy = TRIG_W'(rnd_shift(RND_W'(y_ff[STAGES]), CORDIC_DROP));
      cos_in = n_ff[STAGES] ? -cx : cx;
      sin_in = n_ff[STAGES] ? -sy : sy;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j <= STAGES; j++) begin
            x_ff[j] <= x_in[j];
            y_ff[j] <= y_in[j];
            z_ff[j] <= z_in[j];
            n_ff[j] <= n_in[j];
         end
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign cos_q20 = cos_ff;
   assign sin_q20 = sin_ff;

endmodule

// ----- hdl/curve_point_pivot_transform.sv -----
// Top level: curve sample generation, pivot scale, rotation and pixel rounding.
// Depends on cpt_pkg, cpt_rot_angle and cpt_cordic.
//
//   Channel   Direction  Transfer when              Payload
//   req_      in         req_tvalid & req_tready    tuser: command; tdata: sample fields
//   rsp_      out        rsp_tvalid & rsp_tready    tdata: pixel_x, pixel_y
//   csr_      in         csr_we                     csr_addr, csr_wdata
//
// One sample is taken per cycle while the skid register is empty. A sample passes through
// four input stages, the CORDIC pipelines of TRIG_STAGES + 2 stages each running side by
// side, and nine stages of point arithmetic, then the output register raises rsp_tvalid.
// Reset is synchronous; it empties the pipeline and restores the register defaults.
// A stalled result sits in the output register while one more result drops into a skid
// register; the pipeline halts only while the skid register is full.
module curve_point_pivot_transform
   import cpt_pkg::*;
#(
   parameter int COORD_FRAC_BITS = 4,
   parameter int TRIG_STAGES     = 16
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [0:0]   req_tuser,   // [0] command
   // [15:0] origin_x, [31:16] origin_y, [46:32] axis_a, [61:47] axis_b,
   // [85:62] curvature_k, [101:86] phase, [117:102] sample_offset, [119:118] zero
   input  logic [119:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,   // [15:0] pixel_x, [31:16] pixel_y
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [15:0]  csr_wdata
);

   localparam int LAT_TRIG = TRIG_STAGES + 2;
   localparam int E        = 4 + LAT_TRIG;
   localparam int N        = E + 9;
   localparam int OUT_SH   = COORD_FRAC_BITS + EXTRA_BITS;
   localparam int PAR_SH   = PAR_SHIFT_BASE + COORD_FRAC_BITS;

   // Configuration registers.
   logic signed [15:0] pivot_x_ff, pivot_y_ff, shift_x_ff, shift_y_ff;
   logic [15:0]        scale_h_ff, scale_v_ff;
   logic [14:0]        rot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pivot_x_ff <= '0;
         pivot_y_ff <= '0;
         scale_h_ff <= 16'd4096;
         scale_v_ff <= 16'd4096;
         rot_ff     <= '0;
         shift_x_ff <= '0;
         shift_y_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_PIVOT_X:  pivot_x_ff <= csr_wdata;
            REG_PIVOT_Y:  pivot_y_ff <= csr_wdata;
            REG_SCALE_H:  scale_h_ff <= csr_wdata;
            REG_SCALE_V:  scale_v_ff <= csr_wdata;
            REG_ROTATION: rot_ff     <= csr_wdata[14:0];
            REG_SHIFT_X:  shift_x_ff <= csr_wdata;
            REG_SHIFT_Y:  shift_y_ff <= csr_wdata;
            default:      ;
         endcase
      end
   end

   logic signed [23:0] pvx_up, pvy_up, shx_up, shy_up;
   assign pvx_up = $signed({pivot_x_ff, {EXTRA_BITS{1'b0}}});
   assign pvy_up = $signed({pivot_y_ff, {EXTRA_BITS{1'b0}}});
   assign shx_up = $signed({shift_x_ff, {EXTRA_BITS{1'b0}}});
   assign shy_up = $signed({shift_y_ff, {EXTRA_BITS{1'b0}}});

   // Pipeline control: every stage moves together while the skid register is empty.
   logic         en;
   logic [N:1]   v_ff;
   logic         o_v_ff, s_v_ff;
   logic [31:0]  o_data_ff, s_data_ff;

   assign en         = !s_v_ff;
   assign req_tready = en;
   assign rsp_tvalid = o_v_ff;
   assign rsp_tdata  = o_data_ff;

   // Stage 1: input capture.
   logic               c1_ff;
   logic signed [15:0] ox1_ff, oy1_ff, t1_ff;
   logic [14:0]        a1_ff, b1_ff;
   logic signed [23:0] k1_ff;
   logic [15:0]        ph1_ff;
   // Stage 2: offset squared.
   logic               c2_ff;
   logic signed [15:0] ox2_ff, oy2_ff, t2_ff;
   logic [14:0]        a2_ff, b2_ff;
   logic signed [23:0] k2_ff;
   logic [15:0]        ph2_ff;
   logic signed [31:0] tt_in, tt2_ff;
   // Stage 3: curvature product.
   logic               c3_ff;
   logic signed [15:0] ox3_ff, oy3_ff, t3_ff;
   logic [14:0]        a3_ff, b3_ff;
   logic [15:0]        ph3_ff;
   logic signed [55:0] kt_in, kt3_ff;
   // Stage 4: parabola point.
   logic               c4_ff;
   logic signed [15:0] ox4_ff, oy4_ff;
   logic [14:0]        a4_ff, b4_ff;
   logic [31:0]        ea4_ang_ff;
   logic signed [P_W-1:0] pxp_in, pyp_in, pxp4_ff, pyp4_ff;
   logic signed [16:0] ot_sum;

   always_comb begin
      tt_in  = t1_ff * t1_ff;
      kt_in  = k2_ff * tt2_ff;
      ot_sum = 17'(ox3_ff) + 17'(t3_ff);
      pxp_in = P_W'($signed({ot_sum, {EXTRA_BITS{1'b0}}}));
      pyp_in = P_W'($signed({oy3_ff, {EXTRA_BITS{1'b0}}}))
             + P_W'(rnd_shift(RND_W'(kt3_ff), PAR_SH));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c1_ff  <= req_tuser[0];
         ox1_ff <= req_tdata[15:0];
         oy1_ff <= req_tdata[31:16];
         a1_ff  <= req_tdata[46:32];
         b1_ff  <= req_tdata[61:47];
         k1_ff  <= req_tdata[85:62];
         ph1_ff <= req_tdata[101:86];
         t1_ff  <= req_tdata[117:102];

         c2_ff  <= c1_ff;   ox2_ff <= ox1_ff; oy2_ff <= oy1_ff; t2_ff <= t1_ff;
         a2_ff  <= a1_ff;   b2_ff  <= b1_ff;  k2_ff  <= k1_ff;  ph2_ff <= ph1_ff;
         tt2_ff <= tt_in;

         c3_ff  <= c2_ff;   ox3_ff <= ox2_ff; oy3_ff <= oy2_ff; t3_ff <= t2_ff;
         a3_ff  <= a2_ff;   b3_ff  <= b2_ff;  ph3_ff <= ph2_ff;
         kt3_ff <= kt_in;

         c4_ff  <= c3_ff;   ox4_ff <= ox3_ff; oy4_ff <= oy3_ff;
         a4_ff  <= a3_ff;   b4_ff  <= b3_ff;
         ea4_ang_ff <= {ph3_ff, 16'h0000};
         pxp4_ff <= pxp_in;
         pyp4_ff <= pyp_in;
      end
   end

   // Rotation angle conversion runs in step with stages 1 to 4.
   logic [31:0] rot_turn;
   cpt_rot_angle u_rot_angle (
      .clock       (clock),
      .en          (en),
      .angle_deg64 (rot_ff),
      .rot_turn    (rot_turn)
   );

   // Both trig units start from stage 4.
   logic signed [TRIG_W-1:0] ce, se, cr, sr;
   cpt_cordic #(.STAGES(TRIG_STAGES)) u_trig_phase (
      .clock   (clock),
      .en      (en),
      .angle   (ea4_ang_ff),
      .cos_q20 (ce),
      .sin_q20 (se)
   );
   cpt_cordic #(.STAGES(TRIG_STAGES)) u_trig_rot (
      .clock   (clock),
      .en      (en),
      .angle   (rot_turn),
      .cos_q20 (cr),
      .sin_q20 (sr)
   );

   // Sample fields ride alongside the trig units.
   logic                  dc_ff  [LAT_TRIG];
   logic signed [15:0]    dox_ff [LAT_TRIG];
   logic signed [15:0]    doy_ff [LAT_TRIG];
   logic [14:0]           da_ff  [LAT_TRIG];
   logic [14:0]           db_ff  [LAT_TRIG];
   logic signed [P_W-1:0] dpx_ff [LAT_TRIG];
   logic signed [P_W-1:0] dpy_ff [LAT_TRIG];

   always_ff @(posedge clock) begin
      if (en) begin
         dc_ff[0]  <= c4_ff;   dox_ff[0] <= ox4_ff; doy_ff[0] <= oy4_ff;
         da_ff[0]  <= a4_ff;   db_ff[0]  <= b4_ff;
         dpx_ff[0] <= pxp4_ff; dpy_ff[0] <= pyp4_ff;
         for (int j = 1; j < LAT_TRIG; j++) begin
            dc_ff[j]  <= dc_ff[j-1];  dox_ff[j] <= dox_ff[j-1]; doy_ff[j] <= doy_ff[j-1];
            da_ff[j]  <= da_ff[j-1];  db_ff[j]  <= db_ff[j-1];
            dpx_ff[j] <= dpx_ff[j-1]; dpy_ff[j] <= dpy_ff[j-1];
         end
      end
   end

   // Stage E+1: ellipse axis products.
   logic signed [37:0]       ea_in, eb_in, ea_ff, eb_ff;
   logic                     c5_ff;
   logic signed [15:0]       ox5_ff, oy5_ff;
   logic signed [P_W-1:0]    pxp5_ff, pyp5_ff;
   logic signed [TRIG_W-1:0] cr5_ff, sr5_ff;
   // Stage E+2: curve point.
   logic signed [P_W-1:0]    px_in, py_in, px_ff, py_ff;
   logic signed [TRIG_W-1:0] cr6_ff, sr6_ff;
   // Stage E+3: offset from pivot.
   logic signed [D_W-1:0]    dx_in, dy_in, dx_ff, dy_ff;
   logic signed [TRIG_W-1:0] cr7_ff, sr7_ff;
   // Stage E+4: scale products.
   logic signed [SP_W-1:0]   spx_in, spy_in, spx_ff, spy_ff;
   logic signed [TRIG_W-1:0] cr8_ff, sr8_ff;
   // Stage E+5: scaled point.
   logic signed [X_W-1:0]    xs_in, ys_in, xs_ff, ys_ff;
   logic signed [TRIG_W-1:0] cr9_ff, sr9_ff;
   // Stage E+6: rotation products.
   logic signed [RP_W-1:0]   xc_in, ys_p_in, xs_p_in, yc_in;
   logic signed [RP_W-1:0]   xc_ff, ysn_ff, xsn_ff, yc_ff;
   // Stage E+7: rotated point.
   logic signed [RS_W-1:0]   rxs, rys;
   logic signed [R_W-1:0]    rx_in, ry_in, rx_ff, ry_ff;
   // Stage E+8: translated point.
   logic signed [T_W-1:0]    tx_in, ty_in, tx_ff, ty_ff;
   // Stage E+9: pixel.
   logic signed [RND_W-1:0]  rpx, rpy;
   logic signed [15:0]       pix_x_in, pix_y_in, pix_x_ff, pix_y_ff;

   always_comb begin
      ea_in   = $signed({1'b0, da_ff[LAT_TRIG-1]}) * ce;
      eb_in   = $signed({1'b0, db_ff[LAT_TRIG-1]}) * se;

      if (c5_ff == CMD_PARABOLA) begin
         px_in = pxp5_ff;
         py_in = pyp5_ff;
      end else begin
         px_in = P_W'($signed({ox5_ff, {EXTRA_BITS{1'b0}}}))
               + P_W'(rnd_shift(RND_W'(ea_ff), ELL_SHIFT));
         py_in = P_W'($signed({oy5_ff, {EXTRA_BITS{1'b0}}}))
               + P_W'(rnd_shift(RND_W'(eb_ff), ELL_SHIFT));
      end

      dx_in   = D_W'(px_ff) - D_W'(pvx_up);
      dy_in   = D_W'(py_ff) - D_W'(pvy_up);
      spx_in  = dx_ff * $signed({1'b0, scale_h_ff});
      spy_in  = dy_ff * $signed({1'b0, scale_v_ff});
      xs_in   = X_W'(rnd_shift(RND_W'(spx_ff), SCALE_FRAC));
      ys_in   = X_W'(rnd_shift(RND_W'(spy_ff), SCALE_FRAC));

      xc_in   = xs_ff * cr9_ff;
      ys_p_in = ys_ff * sr9_ff;
      xs_p_in = xs_ff * sr9_ff;
      yc_in   = ys_ff * cr9_ff;

      rxs     = RS_W'(xc_ff) - RS_W'(ysn_ff);
      rys     = RS_W'(xsn_ff) + RS_W'(yc_ff);
      rx_in   = R_W'(rnd_shift(RND_W'(rxs), TRIG_FRAC));
      ry_in   = R_W'(rnd_shift(RND_W'(rys), TRIG_FRAC));

      tx_in   = T_W'(rx_ff) + T_W'(pvx_up) + T_W'(shx_up);
      ty_in   = T_W'(ry_ff) + T_W'(pvy_up) + T_W'(shy_up);

      // Round to whole pixels and clamp to the 16-bit range.
      rpx = rnd_shift(RND_W'(tx_ff), OUT_SH);
      rpy = rnd_shift(RND_W'(ty_ff), OUT_SH);
      if (rpx > 72'sd32767) begin
         pix_x_in = 16'sh7FFF;
      end else if (rpx < -72'sd32768) begin
         pix_x_in = 16'sh8000;
      end else begin
         pix_x_in = rpx[15:0];
      end
      if (rpy > 72'sd32767) begin
         pix_y_in = 16'sh7FFF;
      end else if (rpy < -72'sd32768) begin
         pix_y_in = 16'sh8000;
      end else begin
         pix_y_in = rpy[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ea_ff   <= ea_in;                eb_ff   <= eb_in;
         c5_ff   <= dc_ff[LAT_TRIG-1];
         ox5_ff  <= dox_ff[LAT_TRIG-1];   oy5_ff  <= doy_ff[LAT_TRIG-1];
         pxp5_ff <= dpx_ff[LAT_TRIG-1];   pyp5_ff <= dpy_ff[LAT_TRIG-1];
         cr5_ff  <= cr;                   sr5_ff  <= sr;

         px_ff   <= px_in;   py_ff  <= py_in;   cr6_ff <= cr5_ff; sr6_ff <= sr5_ff;
         dx_ff   <= dx_in;   dy_ff  <= dy_in;   cr7_ff <= cr6_ff; sr7_ff <= sr6_ff;
         spx_ff  <= spx_in;  spy_ff <= spy_in;  cr8_ff <= cr7_ff; sr8_ff <= sr7_ff;
         xs_ff   <= xs_in;   ys_ff  <= ys_in;   cr9_ff <= cr8_ff; sr9_ff <= sr8_ff;

         xc_ff   <= xc_in;   ysn_ff <= ys_p_in; xsn_ff <= xs_p_in; yc_ff <= yc_in;
         rx_ff   <= rx_in;   ry_ff  <= ry_in;
         tx_ff   <= tx_in;   ty_ff  <= ty_in;
         pix_x_ff <= pix_x_in;
         pix_y_ff <= pix_y_in;
      end
   end

   // Valid bits and the output/skid pair.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff   <= '0;
         o_v_ff <= 1'b0;
         s_v_ff <= 1'b0;
      end else begin
         if (en) begin
            v_ff <= {v_ff[N-1:1], req_tvalid};
         end
         if (s_v_ff) begin
            if (rsp_tready) begin
               o_data_ff <= s_data_ff;
               s_v_ff    <= 1'b0;
            end
         end else if (v_ff[N]) begin
            if (o_v_ff && !rsp_tready) begin
               s_v_ff    <= 1'b1;
               s_data_ff <= {pix_y_ff, pix_x_ff};
            end else begin
               o_v_ff    <= 1'b1;
               o_data_ff <= {pix_y_ff, pix_x_ff};
            end
         end else if (rsp_tready) begin
            o_v_ff <= 1'b0;
         end
      end
   end

   // The skid register is only ever filled behind a held result.
   assert property (@(posedge clock) disable iff (reset) s_v_ff |-> o_v_ff)
      else $error("skid register full while output register empty");

   // A halted pipeline keeps its valid bits.
   assert property (@(posedge clock) disable iff (reset) !en |=> $stable(v_ff))
      else $error("pipeline valid bits moved while halted");

   // A finished result behind a stalled output lands in the skid register.
   assert property (@(posedge clock) disable iff (reset)
      (o_v_ff && !rsp_tready && en && v_ff[N]) |=> s_v_ff)
      else $error("finished result was dropped behind a stalled output");

   // Draining the skid register leaves a valid output and frees the pipeline.
   assert property (@(posedge clock) disable iff (reset)
      (s_v_ff && rsp_tready) |=> (!s_v_ff && o_v_ff))
      else $error("skid register did not drain into the output register");

endmodule

// ----- bench/curve_point_pivot_transform_tb.sv -----
// Testbench for curve_point_pivot_transform: ellipse and parabola samples under
// several pivot, scale, rotation and shift settings. Depends on cpt_pkg and the RTL.
`timescale 1ns / 100ps

module curve_point_pivot_transform_tb;
   import cpt_pkg::*;

   localparam int FRAC = 4;
   localparam int STAGES = 16;
   localparam int DRAIN_CYCLES = STAGES + 40;
   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic signed [15:0] pixel_y;
      logic signed [15:0] pixel_x;
   } pixel_t;

   typedef struct {
      command_type        cmd;
      logic signed [15:0] origin_x;
      logic signed [15:0] origin_y;
      logic [14:0]        axis_a;
      logic [14:0]        axis_b;
      logic signed [23:0] curvature_k;
      logic [15:0]        phase;
      logic signed [15:0] sample_offset;
   } sample_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [0:0] req_tuser = '0;
   logic [119:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [2:0] csr_addr = '0;
   logic [15:0] csr_wdata = '0;

   // Shadow copy of the configuration registers.
   logic signed [15:0] cfg_pivot_x, cfg_pivot_y, cfg_shift_x, cfg_shift_y;
   logic [15:0] cfg_scale_h, cfg_scale_v;
   logic [14:0] cfg_rotation;

   pixel_t expected_pixels[$];
   int errors = 0;
   int results_seen = 0;
   int samples_sent = 0;
   int idle_cycles = 0;
   bit calm = 1'b0;

   curve_point_pivot_transform u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Rounding half away from zero.
   function automatic longint round_away(longint v, int sh);
      longint mag;
      mag = (v < 0) ? -v : v;
      mag = (mag + (64'sd1 <<< (sh - 1))) >>> sh;
      return (v < 0) ? -mag : mag;
   endfunction

   // CORDIC cosine and sine in Q20 for an angle in 2^-32 turn.
   task automatic cordic_cos_sin(input logic [31:0] ang, output longint c, output longint s);
      longint z, x, y, nx;
      bit flip;
      z = ang[31] ? longint'(ang) - (64'sd1 <<< 32) : longint'(ang);
      x = 652032874;
      y = 0;
      flip = 1'b0;
      if (z > (64'sd1 <<< 30)) begin
         z -= 64'sd1 <<< 31;
         flip = 1'b1;
      end else if (z < -(64'sd1 <<< 30)) begin
         z += 64'sd1 <<< 31;
         flip = 1'b1;
      end
      for (int i = 0; i < STAGES; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= longint'(ATAN_TURN32[i]);
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += longint'(ATAN_TURN32[i]);
         end
         x = nx;
      end
      x = round_away(x, 10);
      y = round_away(y, 10);
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   function automatic logic signed [15:0] saturate_pixel(longint v);
      longint p;
      p = round_away(v, FRAC + 8);
      if (p > 32767) p = 32767;
      if (p < -32768) p = -32768;
      return p[15:0];
   endfunction

   // Expected pixel for one sample under the current configuration.
   task automatic transform_sample(input sample_t smp, output pixel_t pix);
      longint px, py, c, s, x, y, rx, ry, pvx, pvy, ang;
      logic [31:0] rot;
      pvx = longint'(cfg_pivot_x) * 256;
      pvy = longint'(cfg_pivot_y) * 256;
      ang = longint'(cfg_rotation) % 23040;
      rot = 32'(((ang <<< 32) + 11520) / 23040);
      if (smp.cmd == CMD_ELLIPSE) begin
         cordic_cos_sin({smp.phase, 16'h0}, c, s);
         px = longint'(smp.origin_x) * 256 + round_away(longint'(smp.axis_a) * c, 12);
         py = longint'(smp.origin_y) * 256 + round_away(longint'(smp.axis_b) * s, 12);
      end else begin
         px = (longint'(smp.origin_x) + longint'(smp.sample_offset)) * 256;
         py = longint'(smp.origin_y) * 256 + round_away(longint'(smp.curvature_k)
              * (longint'(smp.sample_offset) * longint'(smp.sample_offset)), 16 + FRAC);
      end
      x = round_away((px - pvx) * longint'(cfg_scale_h), 12);
      y = round_away((py - pvy) * longint'(cfg_scale_v), 12);
      cordic_cos_sin(rot, c, s);
      rx = round_away(x * c - y * s, 20);
      ry = round_away(x * s + y * c, 20);
      pix.pixel_x = saturate_pixel(rx + pvx + longint'(cfg_shift_x) * 256);
      pix.pixel_y = saturate_pixel(ry + pvy + longint'(cfg_shift_y) * 256);
   endtask

   // Result side: random stalls and in-order comparison.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm ? 1'b1 : ($urandom_range(99) >= 6);
         if (rsp_tvalid && rsp_tready) begin
            pixel_t got, want;
            got = rsp_tdata;
            results_seen++;
            if (expected_pixels.size() == 0) begin
               $error("unexpected result pixel_x=%0d pixel_y=%0d", got.pixel_x, got.pixel_y);
               errors++;
            end else begin
               want = expected_pixels.pop_front();
               if (got.pixel_x !== want.pixel_x) begin
                  $error("pixel_x expected %0d got %0d", want.pixel_x, got.pixel_x);
                  errors++;
               end
               if (got.pixel_y !== want.pixel_y) begin
                  $error("pixel_y expected %0d got %0d", want.pixel_y, got.pixel_y);
                  errors++;
               end
            end
         end
      end
   end

   // Watchdog on cycles with no transfer on either channel.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Send one sample, with an occasional random gap first.
   task automatic send_sample(input sample_t smp);
      pixel_t pix;
      while (!calm && $urandom_range(99) < 6) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      transform_sample(smp, pix);
      req_tvalid <= 1'b1;
      req_tuser <= smp.cmd;
      req_tdata <= {2'b00, smp.sample_offset, smp.phase, smp.curvature_k,
                    smp.axis_b, smp.axis_a, smp.origin_y, smp.origin_x};
      do @(posedge clock); while (!req_tready);
      expected_pixels.push_back(pix);
      samples_sent++;
   endtask

   task automatic pause_sender();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      pause_sender();
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [15:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_PIVOT_X:  cfg_pivot_x = val;
         REG_PIVOT_Y:  cfg_pivot_y = val;
         REG_SCALE_H:  cfg_scale_h = val;
         REG_SCALE_V:  cfg_scale_v = val;
         REG_ROTATION: cfg_rotation = val[14:0];
         REG_SHIFT_X:  cfg_shift_x = val;
         REG_SHIFT_Y:  cfg_shift_y = val;
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [15:0] pvx, pvy, sh, sv, rot, shx, shy);
      write_reg(REG_PIVOT_X, pvx);
      write_reg(REG_PIVOT_Y, pvy);
      write_reg(REG_SCALE_H, sh);
      write_reg(REG_SCALE_V, sv);
      write_reg(REG_ROTATION, rot);
      write_reg(REG_SHIFT_X, shx);
      write_reg(REG_SHIFT_Y, shy);
   endtask

   function automatic sample_t random_sample();
      sample_t smp;
      smp.cmd = command_type'($urandom_range(1));
      smp.origin_x = 16'($urandom);
      smp.origin_y = 16'($urandom);
      smp.axis_a = 15'($urandom);
      smp.axis_b = 15'($urandom);
      smp.curvature_k = 24'($urandom);
      smp.phase = 16'($urandom);
      smp.sample_offset = 16'($urandom);
      // Keep most points on screen so rounding is exercised, not only saturation.
      if ($urandom_range(3) != 0) begin
         smp.origin_x = $signed(16'($urandom_range(8000))) - 16'sd4000;
         smp.origin_y = $signed(16'($urandom_range(8000))) - 16'sd4000;
         smp.axis_a = 15'($urandom_range(3000));
         smp.axis_b = 15'($urandom_range(3000));
         smp.sample_offset = $signed(16'($urandom_range(4000))) - 16'sd2000;
         smp.curvature_k = $signed(24'($urandom_range(400000))) - 24'sd200000;
      end
      return smp;
   endfunction

   // Extremes of every field and both commands at reset configuration.
   task automatic test_directed_fields();
      sample_t smp;
      smp = '{CMD_ELLIPSE, 16'sd0, 16'sd0, 15'd0, 15'd0, 24'sd0, 16'd0, 16'sd0};
      send_sample(smp);
      smp = '{CMD_ELLIPSE, 16'sd32767, -16'sd32768, 15'h7FFF, 15'h7FFF, 24'sd0, 16'd0, 16'sd0};
      send_sample(smp);
      for (int p = 0; p < 8; p++) begin
         smp = '{CMD_ELLIPSE, 16'sd160, -16'sd96, 15'd800, 15'd400, 24'h7FFFFF,
                 16'(p * 8192 + (p == 7 ? 8191 : 0)), -16'sd1};
         send_sample(smp);
      end
      smp = '{CMD_ELLIPSE, -16'sd32768, 16'sd32767, 15'h7FFF, 15'h7FFF, -24'sd1, 16'hFFFF, 16'sd5};
      send_sample(smp);
      smp = '{CMD_PARABOLA, 16'sd0, 16'sd0, 15'h7FFF, 15'h7FFF, 24'sd8388607, 16'hFFFF, 16'sd32767};
      send_sample(smp);
      smp = '{CMD_PARABOLA, 16'sd0, 16'sd0, 15'd0, 15'd0, -24'sd8388608, 16'd0, -16'sd32768};
      send_sample(smp);
      smp = '{CMD_PARABOLA, 16'sd100, -16'sd50, 15'd1, 15'd2, 24'sd16777, 16'd3, 16'sd320};
      send_sample(smp);
      smp = '{CMD_PARABOLA, 16'sd32767, 16'sd32767, 15'd0, 15'd0, 24'sd1, 16'd0, 16'sd32767};
      send_sample(smp);
      smp = '{CMD_PARABOLA, -16'sd8, 16'sd8, 15'd0, 15'd0, -24'sd200, 16'd0, -16'sd8};
      send_sample(smp);
      wait_drained();
   endtask

   // Zero scale, largest scale, wrapped angle and extreme pivots and shifts.
   task automatic test_config_extremes();
      write_all(16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'd23040, 16'h7FFF, 16'h8000);
      for (int i = 0; i < 6; i++) send_sample(random_sample());
      wait_drained();
      write_all(16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF);
      for (int i = 0; i < 6; i++) send_sample(random_sample());
      wait_drained();
      // Unused index must leave every register alone.
      csr_we <= 1'b1;
      csr_addr <= 3'd7;
      csr_wdata <= 16'hA5A5;
      @(posedge clock);
      csr_we <= 1'b0;
      for (int i = 0; i < 4; i++) send_sample(random_sample());
      wait_drained();
   endtask

   // Random samples across a series of random configurations.
   task automatic test_random_phases();
      for (int ph = 0; ph < 8; ph++) begin
         write_all(16'($urandom_range(2000) - 1000), 16'($urandom_range(2000) - 1000),
                   16'($urandom_range(8192)), 16'($urandom_range(8192)),
                   16'($urandom_range(32767)), 16'($urandom),
                   16'($urandom_range(4000) - 2000));
         calm = (ph == 3);
         for (int i = 0; i < 70; i++) send_sample(random_sample());
         calm = 1'b0;
         wait_drained();
      end
   endtask

   initial begin
      cfg_pivot_x = 0;
      cfg_pivot_y = 0;
      cfg_scale_h = 4096;
      cfg_scale_v = 4096;
      cfg_rotation = 0;
      cfg_shift_x = 0;
      cfg_shift_y = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_fields();
      test_config_extremes();
      test_random_phases();
      $display("Sent %0d ellipse and parabola samples, checked %0d pixels", samples_sent,
               results_seen);
      $display("over reset, extreme and random pivot, scale, rotation and shift settings.");
      if (errors == 0 && expected_pixels.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- curve_point_pivot_transform.f -----
hdl/cpt_pkg.sv
hdl/cpt_rot_angle.sv
hdl/cpt_cordic.sv
hdl/curve_point_pivot_transform.sv
bench/curve_point_pivot_transform_tb.sv
